// File: src/random_sample_set_macros.svh
// Assertion macros used by the random sample set datapath.
`ifndef RANDOM_SAMPLE_SET_MACROS_SVH
`define RANDOM_SAMPLE_SET_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("random_sample_set: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("random_sample_set: next-cycle check failed");

`endif

// File: src/rss_pkg.sv
// Shared constants, control word types and microcode program of the random sample set.
`default_nettype none

package rss_pkg;

   // Store geometry
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int MOD_W    = IDX_W + 1;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int VAL_W    = 32;
   localparam int RND_W    = 31;
   localparam int BIT_W    = $clog2(RND_W);
   localparam int STATUS_W = 3;
   localparam int REQ_BITS = CMD_W + VAL_W + RND_W;
   localparam int RSP_BITS = STATUS_W + VAL_W + CNT_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

   // Datapath micro-operations
   typedef enum logic [3:0] {
      U_NOP,
      U_LOAD,
      U_READ_INC,
      U_READ_LAST,
      U_MOVE_LAST,
      U_APPEND,
      U_SET_PRESENT,
      U_SET_ABSENT,
      U_SET_FULL,
      U_SET_EMPTY,
      U_MOD_STEP,
      U_READ_REM,
      U_TAKE_SAMPLE,
      U_EMIT
   } uop_type;

   // Jump conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_ACC,
      C_CMD_REM,
      C_CMD_SMP,
      C_CMD_UNUSED,
      C_IDX_END,
      C_NO_MATCH,
      C_CNT_FULL,
      C_CNT_ZERO,
      C_BITS_LEFT,
      C_RSP_BUSY
   } cond_type;

   localparam int PC_W = 5;

   typedef struct packed {
      uop_type         uop;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic acc;
      logic cmd_rem;
      logic cmd_smp;
      logic cmd_unused;
      logic idx_end;
      logic no_match;
      logic cnt_full;
      logic cnt_zero;
      logic bits_left;
      logic rsp_busy;
   } flags_type;

   // Program entry points
   localparam logic [PC_W-1:0] S_IDLE   = 5'd0;
   localparam logic [PC_W-1:0] S_SEARCH = 5'd3;
   localparam logic [PC_W-1:0] S_MOVE   = 5'd7;
   localparam logic [PC_W-1:0] S_MISS   = 5'd9;
   localparam logic [PC_W-1:0] S_FULL   = 5'd12;
   localparam logic [PC_W-1:0] S_ABSENT = 5'd13;
   localparam logic [PC_W-1:0] S_SMP    = 5'd14;
   localparam logic [PC_W-1:0] S_MOD    = 5'd15;
   localparam logic [PC_W-1:0] S_EMPTY  = 5'd18;
   localparam logic [PC_W-1:0] S_EMIT   = 5'd19;

   // Microcode program: perform uop, jump to target if cond holds, else step on
   function automatic ucode_type ucode_at(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         5'd0:    w = '{U_LOAD,        C_NO_ACC,     S_IDLE};
         5'd1:    w = '{U_NOP,         C_CMD_SMP,    S_SMP};
         5'd2:    w = '{U_NOP,         C_CMD_UNUSED, S_EMIT};
         5'd3:    w = '{U_READ_INC,    C_IDX_END,    S_MISS};
         5'd4:    w = '{U_NOP,         C_NO_MATCH,   S_SEARCH};
         5'd5:    w = '{U_NOP,         C_CMD_REM,    S_MOVE};
         5'd6:    w = '{U_SET_PRESENT, C_ALWAYS,     S_EMIT};
         5'd7:    w = '{U_READ_LAST,   C_NEVER,      S_IDLE};
         5'd8:    w = '{U_MOVE_LAST,   C_ALWAYS,     S_EMIT};
         5'd9:    w = '{U_NOP,         C_CMD_REM,    S_ABSENT};
         5'd10:   w = '{U_NOP,         C_CNT_FULL,   S_FULL};
         5'd11:   w = '{U_APPEND,      C_ALWAYS,     S_EMIT};
         5'd12:   w = '{U_SET_FULL,    C_ALWAYS,     S_EMIT};
         5'd13:   w = '{U_SET_ABSENT,  C_ALWAYS,     S_EMIT};
         5'd14:   w = '{U_NOP,         C_CNT_ZERO,   S_EMPTY};
         5'd15:   w = '{U_MOD_STEP,    C_BITS_LEFT,  S_MOD};
         5'd16:   w = '{U_READ_REM,    C_NEVER,      S_IDLE};
         5'd17:   w = '{U_TAKE_SAMPLE, C_ALWAYS,     S_EMIT};
         5'd18:   w = '{U_SET_EMPTY,   C_ALWAYS,     S_EMIT};
         5'd19:   w = '{U_EMIT,        C_RSP_BUSY,   S_EMIT};
         5'd20:   w = '{U_NOP,         C_ALWAYS,     S_IDLE};
         default: w = '{U_NOP,         C_ALWAYS,     S_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: src/rss_sequencer.sv
// Step counter and microcode table that drive the random sample set datapath.
`default_nettype none

module rss_sequencer (
   input  wire                 clock,
   input  wire                 reset,
   input  rss_pkg::flags_type  flags,
   output rss_pkg::ucode_type  ctrl
);
   import rss_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            take;

   // Fetch the current control word
   assign ctrl = ucode_at(pc_ff);

   // Evaluate the jump condition
   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:      take = 1'b0;
         C_ALWAYS:     take = 1'b1;
         C_NO_ACC:     take = ~flags.acc;
         C_CMD_REM:    take = flags.cmd_rem;
         C_CMD_SMP:    take = flags.cmd_smp;
         C_CMD_UNUSED: take = flags.cmd_unused;
         C_IDX_END:    take = flags.idx_end;
         C_NO_MATCH:   take = flags.no_match;
         C_CNT_FULL:   take = flags.cnt_full;
         C_CNT_ZERO:   take = flags.cnt_zero;
         C_BITS_LEFT:  take = flags.bits_left;
         C_RSP_BUSY:   take = flags.rsp_busy;
         default:      take = 1'b0;
      endcase
      pc_in = take ? ctrl.target : pc_ff + PC_W'(1);
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// File: src/rss_datapath.sv
// Value store, search index, serial remainder unit and result register of the set.
`default_nettype none
`include "random_sample_set_macros.svh"

module rss_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  rss_pkg::ucode_type                ctrl,
   output rss_pkg::flags_type                flags,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [rss_pkg::CMD_W-1:0]         req_command,
   input  wire  [rss_pkg::VAL_W-1:0]         req_item_value,
   input  wire  [rss_pkg::RND_W-1:0]         req_random_word,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [rss_pkg::STATUS_W-1:0]      rsp_status,
   output logic [rss_pkg::VAL_W-1:0]         rsp_sampled_value,
   output logic [rss_pkg::CNT_W-1:0]         rsp_member_count
);
   import rss_pkg::*;

   // Value store
   logic [VAL_W-1:0]    mem [CAPACITY];
   logic [VAL_W-1:0]    rdata_ff;
   logic [IDX_W-1:0]    raddr;
   logic [IDX_W-1:0]    waddr;
   logic [VAL_W-1:0]    wdata;
   logic                we;

   // Working registers
   logic [CMD_W-1:0]    cmd_ff;
   logic [VAL_W-1:0]    val_ff;
   logic [RND_W-1:0]    rnd_ff;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [VAL_W-1:0]    smp_ff, smp_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_st_ff;
   logic [VAL_W-1:0]    rsp_smp_ff;
   logic [CNT_W-1:0]    rsp_cnt_ff;

   logic                acc;
   logic                emit;
   logic [MOD_W-1:0]    shifted;
   logic [MOD_W-1:0]    count_ext;

   assign req_tready = (ctrl.uop == U_LOAD);
   assign acc        = req_tvalid & req_tready;
   assign emit       = (ctrl.uop == U_EMIT) & ~flags.rsp_busy;

   // Status for the sequencer
   always_comb begin
      flags.acc        = acc;
      flags.cmd_rem    = (cmd_ff == CMD_REMOVE);
      flags.cmd_smp    = (cmd_ff == CMD_SAMPLE);
      flags.cmd_unused = (cmd_ff == CMD_UNUSED);
      flags.idx_end    = (idx_ff >= count_ff);
      flags.no_match   = (rdata_ff != val_ff);
      flags.cnt_full   = (count_ff >= CNT_W'(CAPACITY));
      flags.cnt_zero   = (count_ff == '0);
      flags.bits_left  = (bit_ff != '0);
      flags.rsp_busy   = rsp_valid_ff & ~rsp_tready;
   end

   // One restoring step of random_word modulo count
   assign shifted   = {rem_ff, rnd_ff[bit_ff]};
   assign count_ext = MOD_W'(count_ff);

   // Decode the micro-operation
   always_comb begin
      raddr        = idx_ff[IDX_W-1:0];
      waddr        = count_ff[IDX_W-1:0];
      wdata        = val_ff;
      we           = 1'b0;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      st_in        = st_ff;
      smp_in       = smp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (ctrl.uop)
         U_NOP: begin
         end
         U_LOAD: begin
            idx_in = '0;
            rem_in = '0;
            bit_in = BIT_W'(RND_W - 1);
            st_in  = ST_OK;
            smp_in = '0;
         end
         U_READ_INC: begin
            idx_in = idx_ff + CNT_W'(1);
         end
         U_READ_LAST: begin
            raddr = IDX_W'(count_ff - CNT_W'(1));
         end
         U_MOVE_LAST: begin
            we       = 1'b1;
            waddr    = IDX_W'(idx_ff - CNT_W'(1));
            wdata    = rdata_ff;
            count_in = count_ff - CNT_W'(1);
         end
         U_APPEND: begin
            we       = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
         U_SET_PRESENT: st_in = ST_PRESENT;
         U_SET_ABSENT:  st_in = ST_ABSENT;
         U_SET_FULL:    st_in = ST_FULL;
         U_SET_EMPTY:   st_in = ST_EMPTY;
         U_MOD_STEP: begin
            if (shifted >= count_ext) begin
               rem_in = IDX_W'(shifted - count_ext);
            end else begin
               rem_in = IDX_W'(shifted);
            end
            bit_in = bit_ff - BIT_W'(1);
         end
         U_READ_REM: begin
            raddr = rem_ff;
         end
         U_TAKE_SAMPLE: begin
            smp_in = rdata_ff;
         end
         U_EMIT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Write and read the store
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold working and result payload
   always_ff @(posedge clock) begin
      if (acc) begin
         cmd_ff <= req_command;
         val_ff <= req_item_value;
         rnd_ff <= req_random_word;
      end
      idx_ff <= idx_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      st_ff  <= st_in;
      smp_ff <= smp_in;
      if (emit) begin
         rsp_st_ff  <= st_ff;
         rsp_smp_ff <= smp_ff;
         rsp_cnt_ff <= count_ff;
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_status        = rsp_st_ff;
   assign rsp_sampled_value = rsp_smp_ff;
   assign rsp_member_count  = rsp_cnt_ff;

   // Checks
   `RSS_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `RSS_ASSERT_SAME(a_append_room, clock, reset, ctrl.uop == U_APPEND, count_ff < CNT_W'(CAPACITY))
   `RSS_ASSERT_SAME(a_move_slot, clock, reset, ctrl.uop == U_MOVE_LAST, (idx_ff != '0) && (idx_ff <= count_ff))
   `RSS_ASSERT_NEXT(a_rem_range, clock, reset, ctrl.uop == U_MOD_STEP, MOD_W'(rem_ff) < MOD_W'(count_ff))
   `RSS_ASSERT_SAME(a_sample_zero, clock, reset, rsp_valid_ff && (rsp_st_ff != ST_OK), rsp_smp_ff == '0)

endmodule

`default_nettype wire

// File: src/random_sample_set.sv
// Top level of the random sample set: stream ports, sequencer and datapath.
//
//   channel  direction  handshake          payload
//   req      in         req_tvalid/tready  req_tdata: command, item_value, random_word
//   rsp      out        rsp_tvalid/tready  rsp_tdata: status, sampled_value, member_count
//
// Insert and remove search the live entries in order, reading and comparing one store
// entry per pass of the search loop, before they act and emit a result.
// Sample derives its index through the 31 one-bit steps of the remainder unit; after
// the emit step every item returns to the load step before the next transfer.
// Reset is synchronous and empties the set; no clearing pass is needed.
// One item is in work at a time; a new item is taken while a finished result waits,
// and the last step stalls only when the result register is still occupied.
`default_nettype none

module random_sample_set (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // [1:0] command, [33:2] item_value, [64:34] random_word, zero fill above
   input  wire  [rss_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // [2:0] status, [34:3] sampled_value, [41:35] member_count, zero fill above
   output logic [rss_pkg::RSP_W-1:0]    rsp_tdata
);
   import rss_pkg::*;

   ucode_type           ctrl;
   flags_type           flags;
   logic [STATUS_W-1:0] rsp_status;
   logic [VAL_W-1:0]    rsp_sampled_value;
   logic [CNT_W-1:0]    rsp_member_count;

   rss_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   rss_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .flags             (flags),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_command       (req_tdata[CMD_W-1:0]),
      .req_item_value    (req_tdata[CMD_W+VAL_W-1:CMD_W]),
      .req_random_word   (req_tdata[REQ_BITS-1:CMD_W+VAL_W]),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_status        (rsp_status),
      .rsp_sampled_value (rsp_sampled_value),
      .rsp_member_count  (rsp_member_count)
   );

   // Pack the result fields, lowest field first
   assign rsp_tdata = RSP_W'({rsp_member_count, rsp_sampled_value, rsp_status});

endmodule

`default_nettype wire

// File: tb/sv/random_sample_set_test.sv
// Self-checking testbench for the random sample set: directed and random set traffic.
module random_sample_set_test;
   import rss_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int TARGET_ITEMS = 520;

   // One reply of the block, split into its fields
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VAL_W-1:0]    sampled;
      logic [CNT_W-1:0]    members;
   } set_reply_t;

   // Tracks the set contents and the replies still owed by the block
   class sample_set_tracker;
      logic [VAL_W-1:0] slots [CAPACITY];
      int unsigned      live;
      set_reply_t       awaited [$];
      int unsigned      mismatches;

      function new();
         live       = 0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      // Apply one accepted command to the tracked set and queue the reply it causes
      function void note_request(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val,
                                 logic [RND_W-1:0] rnd);
         set_reply_t  r;
         int unsigned pos;
         r.status  = ST_OK;
         r.sampled = '0;
         pos       = live;
         for (int unsigned i = 0; i < live; i++) begin
            if (slots[i] == val && pos == live) pos = i;
         end
         case (cmd)
            CMD_INSERT: begin
               if (pos < live) r.status = ST_PRESENT;
               else if (live >= CAPACITY) r.status = ST_FULL;
               else begin
                  slots[live] = val;
                  live++;
               end
            end
            CMD_REMOVE: begin
               if (pos >= live) r.status = ST_ABSENT;
               else begin
                  // fill the hole with the last entry
                  slots[pos] = slots[live - 1];
                  live--;
               end
            end
            CMD_SAMPLE: begin
               if (live == 0) r.status = ST_EMPTY;
               else r.sampled = slots[rnd % live];
            end
            default: ;
         endcase
         r.members = CNT_W'(live);
         awaited = {awaited, r};
      endfunction

      function void report(string what, set_reply_t want, set_reply_t got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: expected status %0d value %h count %0d, got status %0d value %h count %0d",
                     what, want.status, want.sampled, want.members,
                     got.status, got.sampled, got.members);
      endfunction

      // Compare one reply transfer against the oldest awaited reply
      function void check_response(logic [RSP_W-1:0] data);
         set_reply_t got;
         set_reply_t want;
         got.status  = data[STATUS_W-1:0];
         got.sampled = data[STATUS_W +: VAL_W];
         got.members = data[STATUS_W + VAL_W +: CNT_W];
         if (awaited.size() == 0) begin
            report("reply with none awaited", '0, got);
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status || got.sampled !== want.sampled ||
             got.members !== want.members)
            report("reply mismatch", want, got);
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;

   sample_set_tracker    tracker = new();
   logic [VAL_W-1:0]     members [$];
   int                   burst_left = 0;
   int                   items_sent = 0;
   bit                   long_hold_req = 1'b0;
   bit                   hold_seen = 1'b0;
   int                   stall_left = 0;
   int                   ready_mode = 0;
   int                   mode_left = 0;

   random_sample_set u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Track every transfer on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_request(req_tdata[CMD_W-1:0], req_tdata[CMD_W +: VAL_W],
                                 req_tdata[CMD_W + VAL_W +: RND_W]);
         if (rsp_tvalid && rsp_tready)
            tracker.check_response(rsp_tdata);
      end
   end

   // Receiver: long hold on request, otherwise a changing ready pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (long_hold_req != hold_seen) begin
         hold_seen  = long_hold_req;
         stall_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(8, 64);
         end
         mode_left--;
         case (ready_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 1);
            2:       rsp_tready <= ($urandom_range(0, 7) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 14))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [RND_W-1:0] pick_rnd();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return RND_W'($urandom_range(0, 127));
         default: return RND_W'($urandom);
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] pick_member();
      return members[$urandom_range(0, members.size() - 1)];
   endfunction

   // Offer one command, hold it until transfer, then continue the burst or idle
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val,
                               logic [RND_W-1:0] rnd);
      int found;
      found = -1;
      foreach (members[i]) if (members[i] == val && found < 0) found = i;
      if (cmd == CMD_INSERT && found < 0 && members.size() < CAPACITY)
         members = {members, val};
      else if (cmd == CMD_REMOVE && found >= 0)
         members.delete(found);
      items_sent++;
      req_tdata  <= REQ_W'({rnd, val, cmd});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 60)) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // Stop offering and hold until every awaited reply has arrived
   task automatic wait_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // Grow the set to capacity, then knock on the full set
   task automatic fill_set();
      while (members.size() < CAPACITY) begin
         case ($urandom_range(0, 9))
            0: send_command(CMD_SAMPLE, pick_value(), pick_rnd());
            1: send_command(CMD_INSERT, members.size() != 0 ? pick_member() : pick_value(),
                            pick_rnd());
            default: send_command(CMD_INSERT, pick_value(), pick_rnd());
         endcase
      end
      repeat (3) begin
         send_command(CMD_INSERT, $urandom, pick_rnd());
         send_command(CMD_INSERT, pick_member(), pick_rnd());
         send_command(CMD_SAMPLE, $urandom, pick_rnd());
      end
   endtask

   // Shrink the set to empty, then poke the empty set
   task automatic drain_set();
      while (members.size() != 0) begin
         case ($urandom_range(0, 9))
            0:       send_command(CMD_SAMPLE, pick_value(), pick_rnd());
            1:       send_command(CMD_REMOVE, pick_value(), pick_rnd());
            default: send_command(CMD_REMOVE, pick_member(), pick_rnd());
         endcase
      end
      send_command(CMD_SAMPLE, pick_value(), pick_rnd());
      send_command(CMD_REMOVE, pick_value(), pick_rnd());
   endtask

   // Mixed traffic around the current fill level
   task automatic mix_set(int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            send_command(CMD_UNUSED, $urandom, pick_rnd());
         else if (pick < 8)
            send_command(CMD_INSERT, pick_value(), pick_rnd());
         else if (pick < 10)
            send_command(CMD_INSERT, members.size() != 0 ? pick_member() : pick_value(),
                         pick_rnd());
         else if (pick < 15)
            send_command(CMD_REMOVE, members.size() != 0 ? pick_member() : pick_value(),
                         pick_rnd());
         else if (pick < 16)
            send_command(CMD_REMOVE, pick_value(), pick_rnd());
         else
            send_command(CMD_SAMPLE, pick_value(), pick_rnd());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty set, extreme values, duplicates, moves and the unused code
      send_command(CMD_SAMPLE, 32'h0, '0);
      send_command(CMD_REMOVE, 32'h0, '0);
      send_command(CMD_UNUSED, 32'hFFFF_FFFF, '1);
      send_command(CMD_INSERT, 32'h8000_0000, '0);
      send_command(CMD_INSERT, 32'h7FFF_FFFF, '1);
      send_command(CMD_INSERT, 32'h0000_0000, '0);
      send_command(CMD_INSERT, 32'hFFFF_FFFF, '0);
      send_command(CMD_INSERT, 32'h7FFF_FFFF, '0);
      send_command(CMD_SAMPLE, 32'hFFFF_FFFF, '1);
      send_command(CMD_SAMPLE, 32'h0, '0);
      send_command(CMD_SAMPLE, 32'h0, 31'd5);
      send_command(CMD_REMOVE, 32'h8000_0000, '0);
      send_command(CMD_REMOVE, 32'h8000_0000, '1);
      send_command(CMD_REMOVE, 32'h0000_0000, '0);
      send_command(CMD_INSERT, 32'h1234_5678, '0);
      send_command(CMD_UNUSED, 32'h0, '0);
      send_command(CMD_SAMPLE, 32'h0, 31'd1);
      send_command(CMD_REMOVE, 32'h7FFF_FFFF, '0);
      send_command(CMD_REMOVE, 32'hFFFF_FFFF, '0);
      send_command(CMD_REMOVE, 32'h1234_5678, '0);
      send_command(CMD_SAMPLE, 32'h0, '1);
      send_command(CMD_INSERT, 32'h0000_0001, '0);
      send_command(CMD_SAMPLE, 32'h0, '1);

      // Random: fill, pause until drained, empty, then mixed phases
      fill_set();
      wait_replies();
      drain_set();
      long_hold_req <= ~long_hold_req;
      mix_set(60);
      while (items_sent < TARGET_ITEMS) begin
         case ($urandom_range(0, 4))
            0:       fill_set();
            1:       drain_set();
            default: mix_set($urandom_range(30, 80));
         endcase
      end

      wait_replies();
      repeat (300) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/rss_pkg.sv
src/rss_sequencer.sv
src/rss_datapath.sv
src/random_sample_set.sv
tb/sv/random_sample_set_test.sv
